// ----- sv/ser_pkg.sv -----
// ----------------------------------------------------------------------------
// ser_pkg
// Shared types and constants for the sorted table equal range search block.
// ----------------------------------------------------------------------------
package ser_pkg;

    // Fixed field widths of the item channels and the configuration port
    localparam int CMD_W      = 1;
    localparam int IDX_IN_W   = 10;
    localparam int KEY_IN_W   = 32;
    localparam int IDX_OUT_W  = 10;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 11;
    localparam int COUNT_W    = 11;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_WRITE = 1'b0;
    localparam logic [CMD_W-1:0] CMD_QUERY = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIGNED      = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_CMP,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        P_ANY,
        P_FIRST,
        P_LAST
    } t_phase;

endpackage

// ----- sv/ser_in_if.sv -----
// ----------------------------------------------------------------------------
// ser_in_if
// Input item channel: write or query command with index and key.
// ----------------------------------------------------------------------------
interface ser_in_if
    import ser_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CMD_W-1:0]      cmd;
    logic [IDX_IN_W-1:0]   entry_index;
    logic [KEY_IN_W-1:0]   key;

    modport source (output valid, output cmd, output entry_index, output key, input ready);
    modport sink   (input valid, input cmd, input entry_index, input key, output ready);
endinterface

// ----- sv/ser_out_if.sv -----
// ----------------------------------------------------------------------------
// ser_out_if
// Result item channel: found flag with first and last matching index.
// ----------------------------------------------------------------------------
interface ser_out_if
    import ser_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic                  found;
    logic [IDX_OUT_W-1:0]  first_index;
    logic [IDX_OUT_W-1:0]  last_index;

    modport source (output valid, output found, output first_index, output last_index,
                    input ready);
    modport sink   (input valid, input found, input first_index, input last_index,
                    output ready);
endinterface

// ----- sv/ser_ram.sv -----
// ----------------------------------------------------------------------------
// ser_ram
// Generic simple dual-port RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ser_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- sv/sorted_table_equal_range_search.sv -----
// Write item: taken in idle, stored in the key RAM at the accept edge.
// Query item: up to three binary searches (any, first, last match); each probe issues the
// registered key RAM read in S_READ and compares the returned entry in S_CMP, and a miss
// ends after the first search.
// One item at a time; a finished result waits in the output register while the next item is
// taken. Reset clears entry_count, the compare mode and the control state, not the key RAM.
// ----------------------------------------------------------------------------
// sorted_table_equal_range_search
// Binary-search equal range over a sorted key table held in one RAM.
// ----------------------------------------------------------------------------
module sorted_table_equal_range_search
    import ser_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024,
    parameter int KEY_WIDTH   = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    ser_in_if.sink                 i_in,
    ser_out_if.source              o_out
);
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int HW = $clog2(TABLE_DEPTH + 1);

    t_state                r_state, n_state;
    t_phase                r_phase, n_phase;
    logic [HW-1:0]         r_lo, n_lo;
    logic [HW-1:0]         r_hi, n_hi;
    logic [HW-1:0]         r_mid, n_mid;
    logic [HW-1:0]         r_hit, n_hit;
    logic [HW-1:0]         r_n, n_n;
    logic [HW-1:0]         r_first, n_first;
    logic [HW-1:0]         r_last, n_last;
    logic                  r_found, n_found;
    logic [KEY_WIDTH-1:0]  r_qkey, n_qkey;

    logic [COUNT_W-1:0]    r_entry_count;
    logic                  r_signed;

    logic                  r_out_valid, n_out_valid;
    logic                  r_out_found, n_out_found;
    logic [IDX_OUT_W-1:0]  r_out_first, n_out_first;
    logic [IDX_OUT_W-1:0]  r_out_last, n_out_last;

    logic                  accept;
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [KEY_WIDTH-1:0]  ram_wdata;
    logic [AW-1:0]         ram_raddr;
    logic [KEY_WIDTH-1:0]  ram_rdata;
    logic [KEY_WIDTH-1:0]  sign_flip;
    logic [KEY_WIDTH-1:0]  entry_ord;
    logic [HW:0]           mid_sum;
    logic [HW-1:0]         mid;
    logic                  key_lt, key_gt, key_eq;

    ser_ram #(
        .WIDTH (KEY_WIDTH),
        .DEPTH (TABLE_DEPTH)
    ) u_keys (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign i_in.ready        = (r_state == S_IDLE);
    assign accept            = i_in.valid && i_in.ready;
    assign o_out.valid       = r_out_valid;
    assign o_out.found       = r_out_found;
    assign o_out.first_index = r_out_first;
    assign o_out.last_index  = r_out_last;

    // Out-of-range writes are dropped
    assign ram_we    = accept && (i_in.cmd == CMD_WRITE)
                       && (32'(i_in.entry_index) < 32'(TABLE_DEPTH));
    assign ram_waddr = AW'(i_in.entry_index);
    assign ram_wdata = KEY_WIDTH'(i_in.key);

    // Flip the sign bit so signed order becomes unsigned order
    assign sign_flip = KEY_WIDTH'(r_signed) << (KEY_WIDTH - 1);
    assign entry_ord = ram_rdata ^ sign_flip;
    assign key_lt    = r_qkey < entry_ord;
    assign key_gt    = r_qkey > entry_ord;
    assign key_eq    = !key_lt && !key_gt;

    assign mid_sum   = (HW+1)'(r_lo) + (HW+1)'(r_hi);
    assign mid       = mid_sum[HW:1];
    assign ram_raddr = AW'(mid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= '0;
            r_signed      <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ENTRY_COUNT: r_entry_count <= i_cfg_data;
                CFG_SIGNED:      r_signed      <= i_cfg_data[0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= P_ANY;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
        end
        r_lo        <= n_lo;
        r_hi        <= n_hi;
        r_mid       <= n_mid;
        r_hit       <= n_hit;
        r_n         <= n_n;
        r_first     <= n_first;
        r_last      <= n_last;
        r_found     <= n_found;
        r_qkey      <= n_qkey;
        r_out_found <= n_out_found;
        r_out_first <= n_out_first;
        r_out_last  <= n_out_last;
    end

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_mid       = r_mid;
        n_hit       = r_hit;
        n_n         = r_n;
        n_first     = r_first;
        n_last      = r_last;
        n_found     = r_found;
        n_qkey      = r_qkey;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_found = r_out_found;
        n_out_first = r_out_first;
        n_out_last  = r_out_last;

        case (r_state)
            S_IDLE: begin
                if (accept && (i_in.cmd == CMD_QUERY)) begin
                    if (32'(r_entry_count) > 32'(TABLE_DEPTH)) begin
                        n_n = HW'(TABLE_DEPTH);
                    end else begin
                        n_n = HW'(r_entry_count);
                    end
                    n_lo    = '0;
                    n_hi    = n_n;
                    n_phase = P_ANY;
                    n_qkey  = KEY_WIDTH'(i_in.key) ^ sign_flip;
                    n_state = S_READ;
                end
            end
            S_READ: begin
                if (r_lo < r_hi) begin
                    // Probe issued at the midpoint; data comes back next cycle
                    n_mid   = mid;
                    n_state = S_CMP;
                end else begin
                    case (r_phase)
                        P_ANY: begin
                            n_found = 1'b0;
                            n_first = '0;
                            n_last  = '0;
                            n_state = S_DONE;
                        end
                        P_FIRST: begin
                            n_first = r_lo;
                            n_lo    = r_hit + HW'(1);
                            n_hi    = r_n;
                            n_phase = P_LAST;
                        end
                        default: begin
                            n_last  = r_lo - HW'(1);
                            n_found = 1'b1;
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_CMP: begin
                n_state = S_READ;
                case (r_phase)
                    P_ANY: begin
                        if (key_lt) begin
                            n_hi = r_mid;
                        end else if (key_gt) begin
                            n_lo = r_mid + HW'(1);
                        end else begin
                            // Hit: search below it for the first match
                            n_hit   = r_mid;
                            n_lo    = '0;
                            n_hi    = r_mid;
                            n_phase = P_FIRST;
                        end
                    end
                    P_FIRST: begin
                        if (key_eq) begin
                            n_hi = r_mid;
                        end else begin
                            n_lo = r_mid + HW'(1);
                        end
                    end
                    default: begin
                        if (!key_eq) begin
                            n_hi = r_mid;
                        end else begin
                            n_lo = r_mid + HW'(1);
                        end
                    end
                endcase
            end
            S_DONE: begin
                // Hold until the output register is free
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_out_found = r_found;
                    n_out_first = IDX_OUT_W'(r_first);
                    n_out_last  = IDX_OUT_W'(r_last);
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end
endmodule

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for sorted_table_equal_range_search. It loads sorted key
// tables, queries them under unsigned and signed compare, and checks the found
// flag and the first/last index pair of every result against its own model.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ser_pkg::*;

    localparam int          DEPTH             = 1024;
    localparam int          GAP_MAX           = 17;
    localparam int          DRAIN_CYCLES      = 100;
    localparam int          RESULT_WAIT_LIMIT = 20000;
    localparam logic [31:0] SIGN_BIT          = 32'h8000_0000;

    typedef struct packed {
        logic                 found;
        logic [IDX_OUT_W-1:0] first_index;
        logic [IDX_OUT_W-1:0] last_index;
    } t_range;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    ser_in_if  in_ch ();
    ser_out_if out_ch ();

    sorted_table_equal_range_search u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    // Shadow of the key table, updated as write items are accepted, and of the registers
    logic [KEY_IN_W-1:0] key_table [DEPTH];
    int unsigned         cfg_count  = 0;
    bit                  cfg_signed = 1'b0;
    t_range              pending_ranges [$];

    int errors      = 0;
    int n_writes    = 0;
    int n_queries   = 0;
    int n_hits      = 0;
    int n_results   = 0;
    bit gaps_on     = 1'b1;
    int hold_cycles = 0;
    int rx_wait     = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10ms;
        $display("Verification failed");
        $finish;
    end

    function automatic int draw_gap();
        return gaps_on ? int'($urandom_range(0, GAP_MAX)) : 0;
    endfunction

    // Map a key onto an unsigned scale that follows the current compare mode
    function automatic logic [31:0] rank(input logic [31:0] k);
        return cfg_signed ? (k ^ SIGN_BIT) : k;
    endfunction

    function automatic t_range predict_equal_range(input logic [KEY_IN_W-1:0] key);
        int unsigned n, lo, hi, mid, hit;
        bit          hit_ok;
        logic [31:0] q;
        t_range      r;
        n      = (cfg_count > DEPTH) ? DEPTH : cfg_count;
        q      = rank(key);
        lo     = 0;
        hi     = n;
        hit    = 0;
        hit_ok = 1'b0;
        r      = '0;
        while (lo < hi && !hit_ok) begin
            mid = (lo + hi) / 2;
            if (q < rank(key_table[mid])) begin
                hi = mid;
            end else if (q > rank(key_table[mid])) begin
                lo = mid + 1;
            end else begin
                hit    = mid;
                hit_ok = 1'b1;
            end
        end
        if (!hit_ok)
            return r;
        // lowest match below the hit
        lo = 0;
        hi = hit;
        while (lo < hi) begin
            mid = (lo + hi) / 2;
            if (key_table[mid] == key) hi = mid;
            else lo = mid + 1;
        end
        r.found       = 1'b1;
        r.first_index = lo[IDX_OUT_W-1:0];
        // first non-match above the hit
        lo = hit + 1;
        hi = n;
        while (lo < hi) begin
            mid = (lo + hi) / 2;
            if (key_table[mid] != key) hi = mid;
            else lo = mid + 1;
        end
        r.last_index = IDX_OUT_W'(lo - 1);
        return r;
    endfunction

    function automatic logic [31:0] table_key(input int n);
        return (n == 0) ? $urandom() : key_table[$urandom_range(0, n - 1)];
    endfunction

    // Key for a whole-table query: the spine key, one off it, or anything
    function automatic logic [31:0] spine_query(input logic [31:0] spine, input int i);
        case (i % 4)
            0:       return spine;
            1:       return spine + 32'd1;
            2:       return spine - 32'd1;
            default: return $urandom();
        endcase
    endfunction

    task automatic send_item(input logic [CMD_W-1:0]    cmd,
                             input logic [IDX_IN_W-1:0] idx,
                             input logic [KEY_IN_W-1:0] key);
        int     gap;
        t_range r;
        gap = draw_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.cmd         <= cmd;
        in_ch.entry_index <= idx;
        in_ch.key         <= key;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        if (cmd == CMD_WRITE) begin
            key_table[idx] = key;
            n_writes++;
        end else begin
            r = predict_equal_range(key);
            pending_ranges.push_back(r);
            n_queries++;
            if (r.found) n_hits++;
        end
    endtask

    // Drop valid, wait for all results, then let the block finish any write
    task automatic quiesce(input int extra);
        int guard;
        guard = 0;
        in_ch.valid <= 1'b0;
        while (pending_ranges.size() != 0 && guard < RESULT_WAIT_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        if (pending_ranges.size() != 0) begin
            $error("%0d results never arrived", pending_ranges.size());
            errors++;
            pending_ranges.delete();
        end
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= CFG_DATA_W'(value);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_ENTRY_COUNT) cfg_count = value & 32'h7FF;
        else cfg_signed = value[0];
    endtask

    // Write n non-descending keys (in the current compare order) at indices 0..n-1
    task automatic fill_sorted(input int n, input int unsigned max_step, input bit pin_ends);
        logic [32:0] ord;
        int          i;
        ord = pin_ends ? 33'd0 : 33'($urandom_range(0, 32'hF000_0000));
        for (i = 0; i < n; i++) begin
            if (i > 0 && $urandom_range(0, 3) != 0)
                ord = ord + $urandom_range(1, max_step);
            if (ord > 33'h0_FFFF_FFFF || (pin_ends && i == n - 1))
                ord = 33'h0_FFFF_FFFF;
            send_item(CMD_WRITE, IDX_IN_W'(i), ord[31:0] ^ (cfg_signed ? SIGN_BIT : 32'd0));
        end
    endtask

    // Write one key on every entry that a whole-table search can probe. With all
    // probed entries equal, a search only walks toward index 0 or toward the top
    // entry, so the rest of the table is never read.
    task automatic fill_spine(input logic [31:0] k);
        int unsigned lo, hi, mid;
        send_item(CMD_WRITE, IDX_IN_W'(DEPTH / 2), k);
        hi = DEPTH / 2;
        while (hi > 0) begin
            mid = hi / 2;
            send_item(CMD_WRITE, IDX_IN_W'(mid), k);
            hi = mid;
        end
        lo = DEPTH / 2 + 1;
        hi = DEPTH;
        while (lo < hi) begin
            mid = (lo + hi) / 2;
            send_item(CMD_WRITE, IDX_IN_W'(mid), k);
            lo = mid + 1;
        end
    endtask

    task automatic test_directed();
        logic [31:0] dir_keys [8];
        int          i;
        dir_keys = '{32'h0000_0000, 32'h0000_0005, 32'h0000_0005, 32'h0000_0005,
                     32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
        // empty table: nothing is probed
        send_item(CMD_QUERY, '0, 32'h0000_0000);
        send_item(CMD_QUERY, 10'h3FF, 32'hFFFF_FFFF);
        quiesce(DRAIN_CYCLES);
        write_reg(CFG_ENTRY_COUNT, 8);
        for (i = 0; i < 8; i++)
            send_item(CMD_WRITE, IDX_IN_W'(i), dir_keys[i]);
        send_item(CMD_WRITE, 10'h3FF, 32'h1234_5678);
        send_item(CMD_QUERY, 10'h3FF, 32'h0000_0000);
        send_item(CMD_QUERY, '0, 32'h0000_0005);
        send_item(CMD_QUERY, '0, 32'h7FFF_FFFF);
        send_item(CMD_QUERY, '0, 32'h8000_0000);
        send_item(CMD_QUERY, '0, 32'hFFFF_FFFF);
        send_item(CMD_QUERY, '0, 32'h0000_0003);
        send_item(CMD_QUERY, '0, 32'h8000_0001);
        // same table is out of order under signed compare
        quiesce(DRAIN_CYCLES);
        write_reg(CFG_SIGNED, 1);
        send_item(CMD_QUERY, '0, 32'hFFFF_FFFF);
        send_item(CMD_QUERY, '0, 32'h0000_0000);
        send_item(CMD_QUERY, '0, 32'h0000_0005);
        quiesce(DRAIN_CYCLES);
        write_reg(CFG_ENTRY_COUNT, 1);
        send_item(CMD_QUERY, '0, 32'h0000_0000);
        send_item(CMD_QUERY, '0, 32'h0000_0005);
    endtask

    task automatic test_full_table();
        int          i;
        logic [31:0] spine;
        quiesce(DRAIN_CYCLES);
        write_reg(CFG_SIGNED, 1);
        write_reg(CFG_ENTRY_COUNT, 2047);   // above depth: searches the whole table
        spine = $urandom();
        fill_spine(spine);
        for (i = 0; i < 16; i++)
            send_item(CMD_QUERY, IDX_IN_W'($urandom), spine_query(spine, i));
        quiesce(DRAIN_CYCLES);
        write_reg(CFG_ENTRY_COUNT, DEPTH);
        for (i = 0; i < 8; i++)
            send_item(CMD_QUERY, IDX_IN_W'($urandom), spine_query(spine, i));
        quiesce(DRAIN_CYCLES);
        write_reg(CFG_SIGNED, 0);
        for (i = 0; i < 8; i++)
            send_item(CMD_QUERY, IDX_IN_W'($urandom), spine_query(spine, i));
    endtask

    task automatic test_random_phases();
        int          phase, n, i, op;
        logic [31:0] k;
        for (phase = 0; phase < 6; phase++) begin
            quiesce(DRAIN_CYCLES);
            gaps_on = (phase != 4);
            case ($urandom_range(0, 7))
                0: n = 0;
                1: n = 1;
                2: n = 2;
                3: n = 64;
                default: n = $urandom_range(3, 48);
            endcase
            write_reg(CFG_SIGNED, $urandom_range(0, 1));
            write_reg(CFG_ENTRY_COUNT, n);
            fill_sorted(n, $urandom_range(0, 1) ? 4 : (1 << 26), 1'b0);
            for (i = 0; i < 30; i++) begin
                op = $urandom_range(0, 19);
                if (op < 12) begin
                    send_item(CMD_QUERY, IDX_IN_W'($urandom), table_key(n));
                end else if (op < 15) begin
                    k = table_key(n);
                    k = $urandom_range(0, 1) ? k + 1 : k - 1;
                    send_item(CMD_QUERY, IDX_IN_W'($urandom), k);
                end else if (op < 18) begin
                    send_item(CMD_QUERY, IDX_IN_W'($urandom), $urandom());
                end else begin
                    // stray write, may break the order of the searched range
                    send_item(CMD_WRITE, IDX_IN_W'($urandom), $urandom());
                end
            end
        end
        gaps_on = 1'b1;
    endtask

    task automatic test_backpressure();
        int i;
        quiesce(DRAIN_CYCLES);
        write_reg(CFG_SIGNED, 0);
        write_reg(CFG_ENTRY_COUNT, 16);
        fill_sorted(16, 8, 1'b0);
        // hold the result side so the block backs up into the input
        hold_cycles = 400;
        for (i = 0; i < 12; i++)
            send_item(CMD_QUERY, IDX_IN_W'($urandom), table_key(16));
        quiesce(0);
        for (i = 0; i < 12; i++)
            send_item(CMD_QUERY, IDX_IN_W'($urandom), table_key(16));
    endtask

    // Result side: check each accepted result, then draw the next stall
    always @(posedge i_clk) begin
        t_range want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            rx_wait = 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                n_results++;
                if (pending_ranges.size() == 0) begin
                    $error("result with no query pending");
                    errors++;
                end else begin
                    want = pending_ranges.pop_front();
                    if (out_ch.found !== want.found) begin
                        $error("found: expected %0d, actual %0d", want.found, out_ch.found);
                        errors++;
                    end
                    if (out_ch.first_index !== want.first_index) begin
                        $error("first_index: expected %0d, actual %0d",
                               want.first_index, out_ch.first_index);
                        errors++;
                    end
                    if (out_ch.last_index !== want.last_index) begin
                        $error("last_index: expected %0d, actual %0d",
                               want.last_index, out_ch.last_index);
                        errors++;
                    end
                end
                rx_wait = draw_gap();
            end
            if (hold_cycles > 0) begin
                hold_cycles--;
                out_ch.ready <= 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    initial begin
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_idx         = CFG_ENTRY_COUNT;
        i_cfg_data        = '0;
        in_ch.valid       = 1'b0;
        in_ch.cmd         = CMD_WRITE;
        in_ch.entry_index = '0;
        in_ch.key         = '0;
        out_ch.ready      = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_full_table();
        test_random_phases();
        test_backpressure();
        quiesce(DRAIN_CYCLES);

        $display("Covered %0d key writes and %0d queries (%0d hits, %0d results checked)",
                 n_writes, n_queries, n_hits, n_results);
        $display("over unsigned/signed compare, entry counts 0 to 2047 and output stalls.");
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
